### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// condition in the cycle after a trigger
`define ASSERT_NEXT(lbl, clk, rst_n, trig, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

### hw/rtl/adczs_pkg.sv
// types and constants of the adc zero suppression filter
// no dependencies
package adczs_pkg;

  localparam int ADC_W      = 10;
  localparam int PED_W      = 14;
  localparam int NF_W       = 8;
  localparam int CNT_W      = 4;
  localparam int THR_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int PRE_MAX_DEF = 15;

  // fixed point widths of the front arithmetic, in 1/256 counts
  localparam int BASE_W = ADC_W + 9;
  localparam int PROD_W = NF_W + PED_W;
  localparam int V_W    = PROD_W + 2;
  localparam int MAG_W  = ADC_W + 8;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_SUB      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POST         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FACTOR = 3'd4;

  typedef struct packed {
    logic             above;
    logic [ADC_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic   vld;
    entry_t ent;
  } cell_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             ped_sub;
    logic [NF_W-1:0]  noise_factor;
  } front_cfg_t;

endpackage

### hw/rtl/adczs_front.sv
// two-stage front end: pedestal and noise subtraction, clamp, threshold compare
// depends on adczs_pkg
module adczs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  adczs_pkg::front_cfg_t     cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [adczs_pkg::ADC_W-1:0] adc_value_i,
  input  logic [adczs_pkg::PED_W-1:0] pedestal_i,
  input  logic [adczs_pkg::PED_W-1:0] noise_width_i,
  input  logic                      last_sample_i,
  output logic                      ent_vld_o,
  output adczs_pkg::entry_t         ent_o,
  output logic                      ent_last_o,
  input  logic                      ent_take_i
);
  import adczs_pkg::*;

  logic                     s1_vld_q, s2_vld_q;
  logic signed [BASE_W-1:0] s1_base_q, s1_base_d;
  logic [PROD_W-1:0]        s1_prod_q, s1_prod_d;
  logic [ADC_W-1:0]         s1_adc_q;
  logic                     s1_last_q;
  entry_t                   s2_ent_q, s2_ent_d;
  logic                     s2_last_q;

  logic s2_free, s1_free, s1_move, in_acc;
  logic signed [V_W-1:0] v;
  logic [MAG_W-1:0]      vmag;

  assign s2_free    = !s2_vld_q || ent_take_i;
  assign s1_move    = s1_vld_q && s2_free;
  assign s1_free    = !s1_vld_q || s2_free;
  assign in_stall_o = s1_vld_q && !s2_free;
  assign in_acc     = in_valid_i && s1_free;

  // adc*256 - ped*16 and factor*noise, both in 1/256 counts
  assign s1_base_d = $signed({1'b0, adc_value_i, 8'b0} - {1'b0, pedestal_i, 4'b0});
  assign s1_prod_d = PROD_W'(cfg_i.noise_factor) * PROD_W'(noise_width_i);

  always_comb begin
    v = V_W'(s1_base_q) - $signed({{(V_W-PROD_W){1'b0}}, s1_prod_q});
    // below half a count clamps to zero
    if (v < $signed(V_W'(128))) begin
      vmag = '0;
    end else begin
      vmag = v[MAG_W-1:0];
    end
    s2_ent_d.above = vmag > {cfg_i.threshold, 8'b0};
    if (cfg_i.threshold != '0 && cfg_i.ped_sub) begin
      s2_ent_d.val = vmag[MAG_W-1:8];
    end else begin
      s2_ent_d.val = s1_adc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_vld_q <= s1_move;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_base_q <= s1_base_d;
      s1_prod_q <= s1_prod_d;
      s1_adc_q  <= adc_value_i;
      s1_last_q <= last_sample_i;
    end
    if (s1_move) begin
      s2_ent_q  <= s2_ent_d;
      s2_last_q <= s1_last_q;
    end
  end

  assign ent_vld_o  = s2_vld_q;
  assign ent_o      = s2_ent_q;
  assign ent_last_o = s2_last_q;

endmodule

### hw/rtl/adczs_cell.sv
// one slot of the lookahead line: holds a word and shifts toward the head
// depends on adczs_pkg
module adczs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic              ins_i,
  input  logic              prev_vld_i,
  input  adczs_pkg::cell_t  nbr_i,
  input  adczs_pkg::entry_t ent_i,
  output adczs_pkg::cell_t  cell_o
);
  import adczs_pkg::*;

  logic   vld_q;
  entry_t ent_q;
  logic   load;

  // new word lands in the first free slot, one place nearer when shifting
  assign load = ins_i && (shift_i ? (vld_q && !nbr_i.vld) : (!vld_q && prev_vld_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (shift_i) begin
      vld_q <= nbr_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= ent_i;
    end else if (shift_i) begin
      ent_q <= nbr_i.ent;
    end
  end

  assign cell_o.vld = vld_q;
  assign cell_o.ent = ent_q;

endmodule

### hw/rtl/adczs_top.sv
// adc zero suppression filter, top level; depends on adczs_pkg, adczs_front,
// adczs_cell and assert_macros.svh. Samples of one channel enter one per clock
// and results leave one per clock in input order, when no stall holds them. A
// sample passes a two-stage arithmetic front end and then waits in a row of
// PRE_MAX+1 cells until the sample pre_samples places ahead (at least one) has
// arrived, so the first result of a channel shows up max(pre_samples,1)
// samples after its sample. The cell row decides and emits one word a clock
// through a single output register, so the sustained rate is one sample per
// clock while out_stall_i is low. The sample flagged last flushes the row: the
// remaining pending samples, up to max(pre_samples,1) of them, leave one per
// clock while the input is stalled and the output is free. Surplus samples
// of a pre_samples lowering mid-channel leave before the next input goes in.
`include "assert_macros.svh"

module adc_zero_suppression_filter_top #(
  parameter int PRE_MAX = adczs_pkg::PRE_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [adczs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [adczs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [adczs_pkg::ADC_W-1:0]      adc_value_i,
  input  logic [adczs_pkg::PED_W-1:0]      pedestal_i,
  input  logic [adczs_pkg::PED_W-1:0]      noise_width_i,
  input  logic                             last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [adczs_pkg::ADC_W-1:0]      sample_value_o,
  output logic                             suppressed_o,
  output logic                             last_out_o
);
  import adczs_pkg::*;

  localparam int DEPTH = PRE_MAX + 1;
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic MODE_RUN   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // configuration registers
  logic [THR_W-1:0] cfg_thr_q;
  logic             cfg_psub_q;
  logic [CNT_W-1:0] cfg_pre_q;
  logic [CNT_W-1:0] cfg_post_q;
  logic [NF_W-1:0]  cfg_nf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_thr_q  <= '0;
      cfg_psub_q <= 1'b0;
      cfg_pre_q  <= '0;
      cfg_post_q <= '0;
      cfg_nf_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD:    cfg_thr_q  <= cfg_wdata_i[THR_W-1:0];
        CFG_PED_SUB:      cfg_psub_q <= cfg_wdata_i[0];
        CFG_PRE:          cfg_pre_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_POST:         cfg_post_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_NOISE_FACTOR: cfg_nf_q   <= cfg_wdata_i[NF_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  front_cfg_t front_cfg;
  logic       ent_vld, ent_last, consume;
  entry_t     ent;

  assign front_cfg.threshold    = cfg_thr_q;
  assign front_cfg.ped_sub      = cfg_psub_q;
  assign front_cfg.noise_factor = cfg_nf_q;

  adczs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (front_cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .adc_value_i   (adc_value_i),
    .pedestal_i    (pedestal_i),
    .noise_width_i (noise_width_i),
    .last_sample_i (last_sample_i),
    .ent_vld_o     (ent_vld),
    .ent_o         (ent),
    .ent_last_o    (ent_last),
    .ent_take_i    (consume)
  );

  // lookahead line
  cell_t            cells [DEPTH];
  logic [DEPTH-1:0] vld_vec, ins_pos, pres_view, above_view;
  logic             emit;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic  prev_vld;
    cell_t nbr;
    if (g == 0) begin : g_head
      assign prev_vld = 1'b1;
    end else begin : g_body
      assign prev_vld = cells[g-1].vld;
    end
    if (g == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells[g+1];
    end

    adczs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (emit),
      .ins_i      (consume),
      .prev_vld_i (prev_vld),
      .nbr_i      (nbr),
      .ent_i      (ent),
      .cell_o     (cells[g])
    );

    // view after the incoming word is placed, before the head is dropped
    assign vld_vec[g]    = cells[g].vld;
    assign ins_pos[g]    = !cells[g].vld && prev_vld;
    assign pres_view[g]  = cells[g].vld || (consume && ins_pos[g]);
    assign above_view[g] = cells[g].vld ? cells[g].ent.above
                                        : (consume && ins_pos[g] && ent.above);
  end

  // control
  logic [IDX_W-1:0] pre_eff, depth_idx;
  logic             mode_q, mode_d;
  logic [CNT_W-1:0] keep_q, keep_d, keep_nxt;
  logic             out_free, run, occ_depth, occ_dm1, need_emit;
  logic             pre_emit, flush_emit, emit_last;
  logic [ADC_W-1:0] dec_val;
  logic             dec_sup;

  assign pre_eff   = (int'(cfg_pre_q) > PRE_MAX) ? IDX_W'(PRE_MAX) : IDX_W'(cfg_pre_q);
  assign depth_idx = (pre_eff == '0) ? IDX_W'(1) : pre_eff;

  logic             out_vld_q;
  logic [ADC_W-1:0] out_val_q;
  logic             out_sup_q, out_last_q;

  assign out_free  = !out_vld_q || !out_stall_i;
  assign run       = (mode_q == MODE_RUN);
  assign occ_depth = vld_vec[depth_idx];
  assign occ_dm1   = vld_vec[IDX_W'(depth_idx - 1'b1)];
  assign need_emit = ent_last || occ_dm1;

  // surplus words (pre lowered) leave before the next word goes in
  assign pre_emit   = run && ent_vld && occ_depth && out_free;
  assign consume    = run && ent_vld && !occ_depth && (!need_emit || out_free);
  assign flush_emit = !run && out_free;
  assign emit       = pre_emit || flush_emit || (consume && need_emit);
  assign emit_last  = (flush_emit && !vld_vec[1]) || (consume && ent_last && !vld_vec[0]);

  always_comb begin
    dec_val  = vld_vec[0] ? cells[0].ent.val : ent.val;
    dec_sup  = 1'b0;
    keep_nxt = keep_q;
    if (cfg_thr_q == '0) begin
      // filter off: pass
    end else if (keep_q != '0) begin
      keep_nxt = keep_q - 1'b1;
    end else if (above_view[0]) begin
      if (pres_view[1] && !above_view[1]) begin
        keep_nxt = cfg_post_q;
      end
    end else if (pre_eff != '0 && above_view[pre_eff]) begin
      keep_nxt = CNT_W'(pre_eff - 1'b1);
    end else begin
      dec_val = cfg_thr_q - 1'b1;
      dec_sup = 1'b1;
    end
  end

  always_comb begin
    mode_d = mode_q;
    keep_d = keep_q;
    if (emit) begin
      keep_d = emit_last ? '0 : keep_nxt;
    end
    if (consume && ent_last && vld_vec[0]) begin
      mode_d = MODE_FLUSH;
    end else if (flush_emit && !vld_vec[1]) begin
      mode_d = MODE_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RUN;
      keep_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      keep_q <= keep_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_val_q  <= dec_val;
      out_sup_q  <= dec_sup;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sample_value_o = out_val_q;
  assign suppressed_o   = out_sup_q;
  assign last_out_o     = out_last_q;

  // checks
  `ASSERT_PROP(a_flush_has_word, clk_i, rst_ni, (mode_q == MODE_FLUSH) |-> vld_vec[0])
  `ASSERT_PROP(a_line_packed, clk_i, rst_ni, ((vld_vec >> 1) & ~vld_vec) == '0)
  `ASSERT_NEXT(a_end_clears, clk_i, rst_ni, emit && emit_last, (vld_vec == '0) && (keep_q == '0) && (mode_q == MODE_RUN))

endmodule
